### hdl/pss_pkg.sv
// Shared types and codes for the positional sequence store.
`timescale 1ns / 1ps

package pss_pkg;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [6:0]         position;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [6:0]         count;
        logic [1:0]         status;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_REMOVE
    } cell_cmd_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        cell_cmd_t          cmd;
        logic [6:0]         position;
        logic signed [31:0] value;
    } cell_ctl_t;

endpackage

### hdl/positional_sequence_store.sv
// Top level of the positional sequence store: row of cells, count and result register.
`timescale 1ns / 1ps

// Ordered store of up to DEPTH signed 32-bit entries, addressed by position
// (0 is the head). Each transfer is an insert at a position from 0 to the
// count, a remove or a read at a position below the count; every transfer
// gives exactly one result carrying the read value (zero unless a good read),
// the count after the operation and a status (ok, position out of range, or
// store full on insert). The entries sit in a row of DEPTH cells which all
// shift in parallel, so while the input is not stalled the block takes one
// item per cycle and presents its result in the cycle after the input
// transfer; a waiting result holds in the output register and the input side
// is stalled only while that register is full and stalled. Reset empties the
// store; entry contents need no clearing as only positions below the count are ever read.
module positional_sequence_store #(
    parameter int DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pss_pkg::in_item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pss_pkg::out_item_t   out_item
);
    import pss_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 7) ? CW : 7;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_item_reg;
    out_item_t          out_item_next;

    logic               accept;
    logic [PW-1:0]      pos_w;
    logic [PW-1:0]      cnt_w;
    logic [PW-1:0]      cnt_after_w;
    logic               is_full;
    logic [1:0]         status;
    cell_ctl_t          ctl;
    logic signed [31:0] rd_bus;

    logic signed [31:0] cell_data [DEPTH];
    logic signed [31:0] cell_hit  [DEPTH];

    // Hold the input while an unread result is stalled.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign pos_w   = PW'(in_item.position);
    assign cnt_w   = PW'(count_reg);
    assign is_full = (count_reg == CW'(DEPTH));

    // Decode the operation and check its position against the count.
    always_comb
    begin
        status       = ST_OK;
        ctl.cmd      = CMD_NONE;
        ctl.position = in_item.position;
        ctl.value    = in_item.value;
        count_next   = count_reg;
        unique case (in_item.kind)
            KIND_INSERT:
            begin
                if (pos_w > cnt_w)
                    status = ST_RANGE;
                else if (is_full)
                    status = ST_FULL;
                else
                begin
                    ctl.cmd    = accept ? CMD_INSERT : CMD_NONE;
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_REMOVE:
            begin
                if (pos_w >= cnt_w)
                    status = ST_RANGE;
                else
                begin
                    ctl.cmd    = accept ? CMD_REMOVE : CMD_NONE;
                    count_next = count_reg - CW'(1);
                end
            end
            KIND_READ:
            begin
                if (pos_w >= cnt_w)
                    status = ST_RANGE;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // Row of cells; past the position a cell takes its left neighbour on insert, from it on its right on remove.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [31:0] left_d;
            logic signed [31:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = 32'sd0;
            end
            else
            begin : g_inner_l
                assign left_d = cell_data[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_inner_r
                assign right_d = cell_data[gi+1];
            end
            pss_cell #(
                .IDX (gi)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .hit_data   (cell_hit[gi])
            );
        end
    endgenerate

    // Merge the addressed cell onto the read bus; at most one cell drives.
    always_comb
    begin
        rd_bus = 32'sd0;
        for (int i = 0; i < DEPTH; i++)
            rd_bus = rd_bus | cell_hit[i];
    end

    assign cnt_after_w = PW'(count_next);

    always_comb
    begin
        out_item_next.read_value = ((in_item.kind == KIND_READ) && (status == ST_OK))
                                   ? rd_bus : 32'sd0;
        out_item_next.count      = cnt_after_w[6:0];
        out_item_next.status     = status;
        out_valid_next           = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    // Advance the result register on each input transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
            out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count above depth");

    a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.kind == KIND_INSERT && status == ST_OK)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("good insert did not grow the count");

    a_full_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.status == ST_FULL) |-> is_full)
        else $error("full status while store not full");

    a_error_reads_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.status != ST_OK) |-> out_item_reg.read_value == 32'sd0)
        else $error("non-zero read value on refused operation");

    a_result_follows_transfer : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("transfer produced no result");

endmodule

### hdl/pss_cell.sv
// One storage cell of the row: holds one entry and shifts with its neighbours.
`timescale 1ns / 1ps

module pss_cell #(
    parameter int IDX = 0
) (
    input  logic                      clk,
    input  pss_pkg::cell_ctl_t        ctl,
    input  logic signed [31:0]        left_data,
    input  logic signed [31:0]        right_data,
    output logic signed [31:0]        data,
    output logic signed [31:0]        hit_data
);
    import pss_pkg::*;

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               at_pos;
    logic               past_pos;

    assign at_pos   = (IDX == int'(ctl.position));
    assign past_pos = (IDX >  int'(ctl.position));

    always_comb
    begin
        data_next = data_reg;
        case (ctl.cmd)
            CMD_INSERT:
            begin
                if (at_pos)
                    data_next = ctl.value;
                else if (past_pos)
                    data_next = left_data;
            end
            CMD_REMOVE:
            begin
                if (at_pos || past_pos)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // Drive own entry onto the read bus only when addressed.
    assign hit_data = at_pos ? data_reg : 32'sd0;

endmodule
